// ----- rtl/tllc_pkg.sv -----
// ----------------------------------------------------------------------------
// tllc_pkg: shared types of the two-level cache tag model
// Controller states, command and status bundles, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tllc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_MAIN,
        ST_LOOK,
        ST_RD_BI,
        ST_BI,
        ST_RD_FILL,
        ST_FILL,
        ST_RD_WB,
        ST_WB,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        REG_BLOCK_SIZE_LOG2 = 3'd0,
        REG_L1_SIZE_LOG2    = 3'd1,
        REG_L1_WAYS_LOG2    = 3'd2,
        REG_L2_SIZE_LOG2    = 3'd3,
        REG_L2_WAYS_LOG2    = 3'd4,
        REG_WRITE_ALLOCATE  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic latch;
        logic rd_main;
        logic look;
        logic rd_bi;
        logic bi;
        logic rd_fill;
        logic fill;
        logic rd_wb;
        logic wb;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic l1_hit;
        logic l2_hit;
        logic alloc;
        logic l2_victim_valid;
        logic l1_victim_dirty;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/tllc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tllc_ctrl: access sequencer
// Steps one access through lookup, back-invalidate, fill and write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module tllc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire tllc_pkg::status_t st,
    output tllc_pkg::cmd_t         cmd
);
    import tllc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_busy;

    assign out_busy  = out_valid_reg && out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_RD_MAIN;
            ST_RD_MAIN: state_next = ST_LOOK;
            ST_LOOK:
            begin
                if (st.l1_hit)
                    state_next = ST_FINISH;
                else if (st.l2_hit)
                    state_next = st.alloc ? ST_RD_FILL : ST_FINISH;
                else if (!st.alloc)
                    state_next = ST_FINISH;
                else
                    state_next = st.l2_victim_valid ? ST_RD_BI : ST_RD_FILL;
            end
            ST_RD_BI:   state_next = ST_BI;
            ST_BI:      state_next = ST_RD_FILL;
            ST_RD_FILL: state_next = ST_FILL;
            ST_FILL:    state_next = st.l1_victim_dirty ? ST_RD_WB : ST_FINISH;
            ST_RD_WB:   state_next = ST_WB;
            ST_WB:      state_next = ST_FINISH;
            ST_FINISH:  if (!out_busy) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.latch    = (state_reg == ST_IDLE) && in_valid;
        cmd.rd_main  = (state_reg == ST_RD_MAIN);
        cmd.look     = (state_reg == ST_LOOK);
        cmd.rd_bi    = (state_reg == ST_RD_BI);
        cmd.bi       = (state_reg == ST_BI);
        cmd.rd_fill  = (state_reg == ST_RD_FILL);
        cmd.fill     = (state_reg == ST_FILL);
        cmd.rd_wb    = (state_reg == ST_RD_WB);
        cmd.wb       = (state_reg == ST_WB);
        cmd.load_out = (state_reg == ST_FINISH) && !out_busy;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_look_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> ($past(state_reg) == ST_RD_MAIN))
        else $error("lookup without row read");

    a_wb_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> ($past(state_reg) == ST_RD_WB))
        else $error("write-back without row read");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !out_busy) |=> out_valid_reg)
        else $error("result not presented");

endmodule

`default_nettype wire

// ----- rtl/tllc_dp.sv -----
// ----------------------------------------------------------------------------
// tllc_dp: tag stores and access datapath
// Row-wide L1 and L2 tag memories, tag compare, victim choice, LRU ranks.
// ----------------------------------------------------------------------------
`default_nettype none

module tllc_dp #(
    parameter int L1_WAY_LIMIT = 4,
    parameter int L1_SET_LIMIT = 64,
    parameter int L2_WAY_LIMIT = 8,
    parameter int L2_SET_LIMIT = 256,
    parameter int ADDRESS_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tllc_pkg::cmd_t    cmd,
    output tllc_pkg::status_t      st,
    input  wire logic              flush,
    input  wire logic [3:0]        block_size_log2,
    input  wire logic [4:0]        l1_size_log2,
    input  wire logic [1:0]        l1_ways_log2,
    input  wire logic [4:0]        l2_size_log2,
    input  wire logic [1:0]        l2_ways_log2,
    input  wire logic              write_allocate,
    input  wire logic              mode,
    input  wire logic [31:0]       address,
    output logic                   l1_hit,
    output logic                   l2_hit,
    output logic                   memory_fetch,
    output logic                   l1_writeback,
    output logic                   l2_evict,
    output logic                   back_invalidate
);
    import tllc_pkg::*;

    localparam int AW   = ADDRESS_BITS;
    localparam int RW1  = (L1_WAY_LIMIT > 1) ? $clog2(L1_WAY_LIMIT) : 1;
    localparam int RW2  = (L2_WAY_LIMIT > 1) ? $clog2(L2_WAY_LIMIT) : 1;
    localparam int CW1  = $clog2(L1_WAY_LIMIT + 1);
    localparam int CW2  = $clog2(L2_WAY_LIMIT + 1);
    localparam int SW1  = (L1_SET_LIMIT > 1) ? $clog2(L1_SET_LIMIT) : 1;
    localparam int SW2  = (L2_SET_LIMIT > 1) ? $clog2(L2_SET_LIMIT) : 1;
    localparam int M1   = $clog2(L1_SET_LIMIT + 1) - 1;
    localparam int M2   = $clog2(L2_SET_LIMIT + 1) - 1;
    localparam int E1   = AW + 2 + RW1;
    localparam int E2   = AW + 2 + RW2;
    localparam int ROW1 = L1_WAY_LIMIT * E1;
    localparam int ROW2 = L2_WAY_LIMIT * E2;

    // geometry
    logic [4:0]     sb1, sb2;
    logic [CW1-1:0] nw1;
    logic [CW2-1:0] nw2;

    always_comb
    begin
        int e1, e2, w1, w2;
        e1 = int'(l1_size_log2) - int'(block_size_log2) - int'(l1_ways_log2);
        e2 = int'(l2_size_log2) - int'(block_size_log2) - int'(l2_ways_log2);
        if (e1 < 0) e1 = 0;
        if (e1 > M1) e1 = M1;
        if (e2 < 0) e2 = 0;
        if (e2 > M2) e2 = M2;
        w1 = 1 << l1_ways_log2;
        w2 = 1 << l2_ways_log2;
        if (w1 > L1_WAY_LIMIT) w1 = L1_WAY_LIMIT;
        if (w2 > L2_WAY_LIMIT) w2 = L2_WAY_LIMIT;
        sb1 = 5'(e1);
        sb2 = 5'(e2);
        nw1 = CW1'(w1);
        nw2 = CW2'(w2);
    end

    // access registers
    logic          mode_reg;
    logic [AW-1:0] addr_reg;
    logic [SW1-1:0] s1_reg, vs1_reg;
    logic [SW2-1:0] s2_reg, wbs2_reg;
    logic [AW-1:0]  t1_reg, t2_reg, vt1_reg, wbt2_reg;
    logic f_l1_reg, f_l2_reg, f_mem_reg, f_wb_reg, f_ev_reg, f_bi_reg;
    logic alloc;

    assign alloc = !mode_reg || write_allocate;

    logic [63:0] addr64;
    logic [63:0] lo_mask1, lo_mask2;
    logic [SW1-1:0] s1_now;
    logic [SW2-1:0] s2_now;
    logic [AW-1:0]  t1_now, t2_now;

    assign addr64   = 64'(addr_reg);
    assign lo_mask1 = ~({64{1'b1}} << sb1);
    assign lo_mask2 = ~({64{1'b1}} << sb2);

    always_comb
    begin
        logic [63:0] sh1, sh2;
        sh1    = (addr64 >> block_size_log2) & lo_mask1;
        sh2    = (addr64 >> block_size_log2) & lo_mask2;
        s1_now = sh1[SW1-1:0];
        s2_now = sh2[SW2-1:0];
        t1_now = AW'(addr64 >> ({2'b0, block_size_log2} + {1'b0, sb1}));
        t2_now = AW'(addr64 >> ({2'b0, block_size_log2} + {1'b0, sb2}));
    end

    // memories
    logic [ROW1-1:0] l1_mem [L1_SET_LIMIT];
    logic [ROW2-1:0] l2_mem [L2_SET_LIMIT];
    logic [L1_SET_LIMIT-1:0] l1_rowv_reg;
    logic [L2_SET_LIMIT-1:0] l2_rowv_reg;
    logic [ROW1-1:0] rd1_reg, wr1_row;
    logic [ROW2-1:0] rd2_reg, wr2_row;
    logic            ok1_reg, ok2_reg;
    logic            rd1_en, rd2_en, wr1_en, wr2_en;
    logic [SW1-1:0]  rd1_idx, wr1_idx;
    logic [SW2-1:0]  rd2_idx, wr2_idx;

    assign rd1_en  = cmd.rd_main || cmd.rd_bi || cmd.rd_fill;
    assign rd2_en  = cmd.rd_main || cmd.rd_wb;
    assign rd1_idx = cmd.rd_main ? s1_now : (cmd.rd_bi ? vs1_reg : s1_reg);
    assign rd2_idx = cmd.rd_main ? s2_now : wbs2_reg;
    assign wr1_idx = cmd.bi ? vs1_reg : s1_reg;
    assign wr2_idx = cmd.wb ? wbs2_reg : s2_reg;

    always_ff @(posedge clk)
    begin
        if (rd1_en)
            rd1_reg <= l1_mem[rd1_idx];
        if (wr1_en)
            l1_mem[wr1_idx] <= wr1_row;
    end

    always_ff @(posedge clk)
    begin
        if (rd2_en)
            rd2_reg <= l2_mem[rd2_idx];
        if (wr2_en)
            l2_mem[wr2_idx] <= wr2_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_rowv_reg <= '0;
            l2_rowv_reg <= '0;
            ok1_reg     <= 1'b0;
            ok2_reg     <= 1'b0;
        end
        else
        begin
            if (rd1_en)
                ok1_reg <= l1_rowv_reg[rd1_idx];
            if (rd2_en)
                ok2_reg <= l2_rowv_reg[rd2_idx];
            if (flush)
            begin
                l1_rowv_reg <= '0;
                l2_rowv_reg <= '0;
            end
            else
            begin
                if (wr1_en)
                    l1_rowv_reg[wr1_idx] <= 1'b1;
                if (wr2_en)
                    l2_rowv_reg[wr2_idx] <= 1'b1;
            end
        end
    end

    // L1 row
    logic [AW-1:0]  r1_tag   [L1_WAY_LIMIT];
    logic           r1_valid [L1_WAY_LIMIT];
    logic           r1_dirty [L1_WAY_LIMIT];
    logic [RW1-1:0] r1_rank  [L1_WAY_LIMIT];
    logic [RW1-1:0] mru1     [L1_WAY_LIMIT];
    logic [AW-1:0]  k1;
    logic           hit1, inv1;
    logic [RW1-1:0] hw1, vi1, vr1, v1, mt1;

    assign k1 = cmd.bi ? vt1_reg : t1_reg;

    always_comb
    begin
        for (int w = 0; w < L1_WAY_LIMIT; w++)
        begin
            r1_tag[w]   = ok1_reg ? rd1_reg[w*E1 +: AW] : '0;
            r1_valid[w] = ok1_reg ? rd1_reg[w*E1 + AW] : 1'b0;
            r1_dirty[w] = ok1_reg ? rd1_reg[w*E1 + AW + 1] : 1'b0;
            r1_rank[w]  = ok1_reg ? rd1_reg[w*E1 + AW + 2 +: RW1] : RW1'(w);
        end
    end

    always_comb
    begin
        hit1 = 1'b0;
        hw1  = '0;
        inv1 = 1'b0;
        vi1  = '0;
        vr1  = '0;
        for (int w = L1_WAY_LIMIT - 1; w >= 0; w--)
        begin
            if (CW1'(w) < nw1)
            begin
                if (r1_valid[w] && r1_tag[w] == k1)
                begin
                    hit1 = 1'b1;
                    hw1  = RW1'(w);
                end
                if (!r1_valid[w])
                begin
                    inv1 = 1'b1;
                    vi1  = RW1'(w);
                end
                if (r1_rank[w] == '0)
                    vr1 = RW1'(w);
            end
        end
        v1  = inv1 ? vi1 : vr1;
        mt1 = cmd.look ? hw1 : v1;
    end

    always_comb
    begin
        for (int w = 0; w < L1_WAY_LIMIT; w++)
        begin
            mru1[w] = r1_rank[w];
            if (CW1'(w) < nw1)
            begin
                if (RW1'(w) == mt1)
                    mru1[w] = RW1'(nw1 - CW1'(1));
                else if (r1_rank[w] > r1_rank[mt1])
                    mru1[w] = r1_rank[w] - RW1'(1);
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < L1_WAY_LIMIT; w++)
        begin
            logic [AW-1:0]  tg;
            logic           vl, dt;
            logic [RW1-1:0] rk;
            tg = r1_tag[w];
            vl = r1_valid[w];
            dt = r1_dirty[w];
            rk = r1_rank[w];
            if (cmd.look)
            begin
                rk = mru1[w];
                if (RW1'(w) == hw1 && mode_reg)
                    dt = 1'b1;
            end
            else if (cmd.bi)
            begin
                if (RW1'(w) == hw1)
                begin
                    vl = 1'b0;
                    dt = 1'b0;
                end
            end
            else
            begin
                rk = mru1[w];
                if (RW1'(w) == v1)
                begin
                    tg = t1_reg;
                    vl = 1'b1;
                    dt = mode_reg;
                end
            end
            wr1_row[w*E1 +: E1] = {rk, dt, vl, tg};
        end
    end

    assign wr1_en = (cmd.look && hit1) || (cmd.bi && hit1) || cmd.fill;

    // L2 row
    logic [AW-1:0]  r2_tag   [L2_WAY_LIMIT];
    logic           r2_valid [L2_WAY_LIMIT];
    logic           r2_dirty [L2_WAY_LIMIT];
    logic [RW2-1:0] r2_rank  [L2_WAY_LIMIT];
    logic [RW2-1:0] mru2     [L2_WAY_LIMIT];
    logic [AW-1:0]  k2;
    logic           hit2, inv2;
    logic [RW2-1:0] hw2, vi2, vr2, v2, mt2;

    assign k2 = cmd.wb ? wbt2_reg : t2_reg;

    always_comb
    begin
        for (int w = 0; w < L2_WAY_LIMIT; w++)
        begin
            r2_tag[w]   = ok2_reg ? rd2_reg[w*E2 +: AW] : '0;
            r2_valid[w] = ok2_reg ? rd2_reg[w*E2 + AW] : 1'b0;
            r2_dirty[w] = ok2_reg ? rd2_reg[w*E2 + AW + 1] : 1'b0;
            r2_rank[w]  = ok2_reg ? rd2_reg[w*E2 + AW + 2 +: RW2] : RW2'(w);
        end
    end

    always_comb
    begin
        hit2 = 1'b0;
        hw2  = '0;
        inv2 = 1'b0;
        vi2  = '0;
        vr2  = '0;
        for (int w = L2_WAY_LIMIT - 1; w >= 0; w--)
        begin
            if (CW2'(w) < nw2)
            begin
                if (r2_valid[w] && r2_tag[w] == k2)
                begin
                    hit2 = 1'b1;
                    hw2  = RW2'(w);
                end
                if (!r2_valid[w])
                begin
                    inv2 = 1'b1;
                    vi2  = RW2'(w);
                end
                if (r2_rank[w] == '0)
                    vr2 = RW2'(w);
            end
        end
        v2  = inv2 ? vi2 : vr2;
        mt2 = (cmd.look && !hit2) ? v2 : hw2;
    end

    always_comb
    begin
        for (int w = 0; w < L2_WAY_LIMIT; w++)
        begin
            mru2[w] = r2_rank[w];
            if (CW2'(w) < nw2)
            begin
                if (RW2'(w) == mt2)
                    mru2[w] = RW2'(nw2 - CW2'(1));
                else if (r2_rank[w] > r2_rank[mt2])
                    mru2[w] = r2_rank[w] - RW2'(1);
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < L2_WAY_LIMIT; w++)
        begin
            logic [AW-1:0]  tg;
            logic           vl, dt;
            tg = r2_tag[w];
            vl = r2_valid[w];
            dt = r2_dirty[w];
            if (RW2'(w) == mt2)
            begin
                if (cmd.look && !hit2)
                begin
                    tg = t2_reg;
                    vl = 1'b1;
                    dt = 1'b0;
                end
                else if (cmd.wb)
                    dt = 1'b1;
            end
            wr2_row[w*E2 +: E2] = {mru2[w], dt, vl, tg};
        end
    end

    assign wr2_en = (cmd.look && !hit1 && (hit2 || alloc)) || (cmd.wb && hit2);

    // victim address translation between levels
    logic [SW1-1:0] vs1_now;
    logic [AW-1:0]  vt1_now;
    logic [SW2-1:0] wbs2_now;
    logic [AW-1:0]  wbt2_now;

    always_comb
    begin
        logic [63:0] x2, x1, m1, m2;
        x2 = (64'(r2_tag[v2]) << ({1'b0, sb2} + {2'b0, block_size_log2}))
           | (64'(s2_reg) << block_size_log2);
        m1 = (x2 >> block_size_log2) & lo_mask1;
        vs1_now = m1[SW1-1:0];
        vt1_now = AW'(x2 >> ({2'b0, block_size_log2} + {1'b0, sb1}));
        x1 = (64'(r1_tag[v1]) << ({1'b0, sb1} + {2'b0, block_size_log2}))
           | (64'(s1_reg) << block_size_log2);
        m2 = (x1 >> block_size_log2) & lo_mask2;
        wbs2_now = m2[SW2-1:0];
        wbt2_now = AW'(x1 >> ({2'b0, block_size_log2} + {1'b0, sb2}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            addr_reg <= AW'(64'(address));
        end
        if (cmd.rd_main)
        begin
            s1_reg <= s1_now;
            s2_reg <= s2_now;
            t1_reg <= t1_now;
            t2_reg <= t2_now;
        end
        if (cmd.look)
        begin
            vs1_reg <= vs1_now;
            vt1_reg <= vt1_now;
        end
        if (cmd.fill)
        begin
            wbs2_reg <= wbs2_now;
            wbt2_reg <= wbt2_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_l1_reg  <= 1'b0;
            f_l2_reg  <= 1'b0;
            f_mem_reg <= 1'b0;
            f_wb_reg  <= 1'b0;
            f_ev_reg  <= 1'b0;
            f_bi_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                f_l1_reg  <= 1'b0;
                f_l2_reg  <= 1'b0;
                f_mem_reg <= 1'b0;
                f_wb_reg  <= 1'b0;
                f_ev_reg  <= 1'b0;
                f_bi_reg  <= 1'b0;
            end
            if (cmd.look)
            begin
                f_l1_reg  <= hit1;
                f_l2_reg  <= !hit1 && hit2;
                f_mem_reg <= !hit1 && !hit2;
                f_ev_reg  <= !hit1 && !hit2 && alloc && r2_valid[v2];
            end
            if (cmd.bi)
                f_bi_reg <= hit1;
            if (cmd.fill)
                f_wb_reg <= r1_valid[v1] && r1_dirty[v1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            l1_hit          <= f_l1_reg;
            l2_hit          <= f_l2_reg;
            memory_fetch    <= f_mem_reg;
            l1_writeback    <= f_wb_reg;
            l2_evict        <= f_ev_reg;
            back_invalidate <= f_bi_reg;
        end
    end

    always_comb
    begin
        st.l1_hit          = hit1;
        st.l2_hit          = hit2;
        st.alloc           = alloc;
        st.l2_victim_valid = r2_valid[v2];
        st.l1_victim_dirty = r1_valid[v1] && r1_dirty[v1];
    end

endmodule

`default_nettype wire

// ----- rtl/two_level_lru_cache_model_top.sv -----
// ----------------------------------------------------------------------------
// two_level_lru_cache_model_top: inclusive two-level LRU cache tag model
// Register port, access sequencer and tag datapath.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    mode, address
//   out      source     out_valid / out_stall  six event flags
//   cfg      APB        psel/penable/pready    paddr, pwdata, prdata
//
// An access ends at the lookup on an L1 hit, else goes on to back-invalidate,
// fill and write-back as needed; each step follows a registered tag row read.
// Reset and any register write empty both levels at once (row valid bits).
// A waiting result does not block the next beat on the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_lru_cache_model_top #(
    parameter int L1_WAY_LIMIT = 4,
    parameter int L1_SET_LIMIT = 64,
    parameter int L2_WAY_LIMIT = 8,
    parameter int L2_SET_LIMIT = 256,
    parameter int ADDRESS_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [31:0] address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             l1_hit,
    output logic             l2_hit,
    output logic             memory_fetch,
    output logic             l1_writeback,
    output logic             l2_evict,
    output logic             back_invalidate
);
    import tllc_pkg::*;

    logic [3:0] block_size_log2_reg;
    logic [4:0] l1_size_log2_reg;
    logic [1:0] l1_ways_log2_reg;
    logic [4:0] l2_size_log2_reg;
    logic [1:0] l2_ways_log2_reg;
    logic       write_allocate_reg;
    logic       wr_en;
    logic       flush;
    reg_idx_t   idx;
    cmd_t       cmd;
    status_t    st;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        case (idx)
            REG_BLOCK_SIZE_LOG2,
            REG_L1_SIZE_LOG2,
            REG_L1_WAYS_LOG2,
            REG_L2_SIZE_LOG2,
            REG_L2_WAYS_LOG2,
            REG_WRITE_ALLOCATE: flush = wr_en;
            default:            flush = 1'b0;
        endcase
    end

    always_comb
    begin
        case (idx)
            REG_BLOCK_SIZE_LOG2: prdata = {28'b0, block_size_log2_reg};
            REG_L1_SIZE_LOG2:    prdata = {27'b0, l1_size_log2_reg};
            REG_L1_WAYS_LOG2:    prdata = {30'b0, l1_ways_log2_reg};
            REG_L2_SIZE_LOG2:    prdata = {27'b0, l2_size_log2_reg};
            REG_L2_WAYS_LOG2:    prdata = {30'b0, l2_ways_log2_reg};
            REG_WRITE_ALLOCATE:  prdata = {31'b0, write_allocate_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_log2_reg <= 4'd4;
            l1_size_log2_reg    <= 5'd10;
            l1_ways_log2_reg    <= 2'd1;
            l2_size_log2_reg    <= 5'd14;
            l2_ways_log2_reg    <= 2'd2;
            write_allocate_reg  <= 1'b1;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_BLOCK_SIZE_LOG2: block_size_log2_reg <= pwdata[3:0];
                REG_L1_SIZE_LOG2:    l1_size_log2_reg    <= pwdata[4:0];
                REG_L1_WAYS_LOG2:    l1_ways_log2_reg    <= pwdata[1:0];
                REG_L2_SIZE_LOG2:    l2_size_log2_reg    <= pwdata[4:0];
                REG_L2_WAYS_LOG2:    l2_ways_log2_reg    <= pwdata[1:0];
                REG_WRITE_ALLOCATE:  write_allocate_reg  <= pwdata[0];
                default:             ;
            endcase
        end
    end

    tllc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    tllc_dp #(
        .L1_WAY_LIMIT (L1_WAY_LIMIT),
        .L1_SET_LIMIT (L1_SET_LIMIT),
        .L2_WAY_LIMIT (L2_WAY_LIMIT),
        .L2_SET_LIMIT (L2_SET_LIMIT),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .flush           (flush),
        .block_size_log2 (block_size_log2_reg),
        .l1_size_log2    (l1_size_log2_reg),
        .l1_ways_log2    (l1_ways_log2_reg),
        .l2_size_log2    (l2_size_log2_reg),
        .l2_ways_log2    (l2_ways_log2_reg),
        .write_allocate  (write_allocate_reg),
        .mode            (mode),
        .address         (address),
        .l1_hit          (l1_hit),
        .l2_hit          (l2_hit),
        .memory_fetch    (memory_fetch),
        .l1_writeback    (l1_writeback),
        .l2_evict        (l2_evict),
        .back_invalidate (back_invalidate)
    );

endmodule

`default_nettype wire
